>>> sv/aprc_pkg.sv
package aprc_pkg;

  localparam int FILTER_DEPTH = 16;
  localparam int FILL_W = $clog2(FILTER_DEPTH + 1);
  localparam int POS_W = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;

  localparam int PHASE_W = 63;
  localparam int ERR_W = 64;
  localparam int RING_W = 48;
  localparam int SUM_W = 56;
  localparam int FRAC_W = 16;

  localparam int PERIOD_W = 14;
  localparam int ENV_W = 24;
  localparam int HORIZON_W = 24;
  localparam int PPM_W = 17;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 24;

  // |error| stays below 2^40 once it passes the envelope check
  localparam int ERR_MAG_W = ENV_W + FRAC_W + 1;
  localparam int SMAG_W = ERR_MAG_W + FILL_W;
  localparam int DELTA_SHIFT = 14;
  localparam int QUO_W = SMAG_W + DELTA_SHIFT;
  localparam int DEN_W = FILL_W + HORIZON_W;
  localparam int CNT_W = $clog2(QUO_W + 1);

  localparam int RATIO_W = 32;
  localparam int CORR_W = 28;
  localparam int RAT_W = 35;
  localparam int PROD_W = RATIO_W + PERIOD_W;
  localparam int PROD_SHIFT = 14;
  localparam int PPM_SHIFT = 30;

  localparam int PPM_SCALE = 1000000;
  localparam int ONE_Q30 = 1 << 30;

  // ppm * 2^30 / 10^6 = ppm * 1073 + ppm * 11591 / 15625
  localparam int PPM_INT_MUL = 1073;
  // ceil(11591 * 2^31 / 15625), exact over the 17-bit ppm range
  localparam int PPM_FRAC_MUL = 1593054910;
  localparam int PPM_FRAC_SHIFT = 31;
  localparam int PPM_PROD_W = PPM_W + PPM_FRAC_SHIFT;

  localparam logic OP_ARM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PERIOD   = 3'd0,
    REG_ENVELOPE = 3'd1,
    REG_HORIZON  = 3'd2,
    REG_MAX_CORR = 3'd3,
    REG_MAX_SLEW = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_CHK,
    ST_SUM,
    ST_DEN,
    ST_DIV_LOAD,
    ST_DIVIDE,
    ST_REQ,
    ST_SLEW_LO,
    ST_SLEW_HI,
    ST_MUL,
    ST_ADV,
    ST_EMIT
  } state_t;

endpackage

>>> sv/aprc_item_if.sv
interface aprc_item_if import aprc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               operation;
  logic [PHASE_W-1:0] phase_value;

  modport source (output valid, output operation, output phase_value, input ready);
  modport sink (input valid, input operation, input phase_value, output ready);
endinterface

>>> sv/aprc_result_if.sv
interface aprc_result_if import aprc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [RATIO_W-1:0]        resample_ratio;
  logic signed [PHASE_W-1:0] phase_offset;
  logic                      fault;

  modport source (output valid, output resample_ratio, output phase_offset, output fault,
                  input ready);
  modport sink (input valid, input resample_ratio, input phase_offset, input fault,
                output ready);
endinterface

>>> sv/aprc_cfg_if.sv
interface aprc_cfg_if import aprc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/audio_phase_rate_control_loop.sv
// channel   dir  transaction payload
// item      in   operation (0 arm, 1 period update), phase_value Q47.16
// result    out  resample_ratio Q2.30, phase_offset Q47.16 signed, fault
// cfg       in   index 0..4, data (low bits of the register width)
//
// an arm or an update while faulted goes straight to the result; an envelope fault
// stops after the check; a normal update runs all steps, with the restoring divider
// giving one quotient bit a cycle
// item is not ready while an item is in flight; a finished result sits in the
// output register and the next item is taken while it waits
// rst (synchronous) restores register defaults, ratio 1.0 and a clear filter
module audio_phase_rate_control_loop import aprc_pkg::*; (
  input logic          clk,
  input logic          rst,
  aprc_item_if.sink    item,
  aprc_result_if.source result,
  aprc_cfg_if.sink     cfg
);

  state_t state, state_next;

  logic [PERIOD_W-1:0]  period;
  logic [ENV_W-1:0]     envelope;
  logic [HORIZON_W-1:0] horizon;
  logic [PPM_W-1:0]     max_corr;
  logic [PPM_W-1:0]     max_slew;

  logic [PHASE_W-1:0]  source_phase;
  logic [PHASE_W-1:0]  target;
  logic signed [ERR_W-1:0] err;
  logic signed [SUM_W-1:0] error_sum;
  logic [FILL_W-1:0]   fill_count;
  logic [POS_W-1:0]    ring_position;
  logic [RATIO_W-1:0]  ratio_now;
  logic                fault_latched;
  logic                report_err;

  logic [RING_W-1:0]   ring [FILTER_DEPTH];
  logic [RING_W-1:0]   ring_rd;
  logic                ring_we;

  logic [SMAG_W-1:0]   smag;
  logic                sum_neg;
  logic [DEN_W-1:0]    den;
  logic [DEN_W-1:0]    dvs;
  logic [DEN_W-1:0]    rem;
  logic [QUO_W-1:0]    divq;
  logic [CNT_W-1:0]    div_cnt;
  logic [CORR_W-1:0]   corr_q;
  logic [CORR_W-1:0]   slew_q;
  logic signed [RAT_W-1:0] ratio_work;
  logic [PROD_W-1:0]   prod;

  logic                accept;
  logic                out_load;
  logic [ERR_W-1:0]    err_mag;
  logic [DEN_W:0]      rem_sh;
  logic                rem_fits;
  logic [DEN_W:0]      rem_diff;
  logic [CORR_W-1:0]   qmag;
  logic signed [RAT_W-1:0] slew_lo;
  logic signed [RAT_W-1:0] slew_hi;
  logic signed [RAT_W-1:0] hi_clamped;
  logic [RATIO_W-1:0]  ratio_sat;
  logic [PHASE_W:0]    phase_sum;
  logic [HORIZON_W-1:0] horizon_eff;
  logic signed [SUM_W-1:0] err_ext;
  logic signed [SUM_W-1:0] old_ext;
  logic signed [PHASE_W-1:0] err_sat;
  logic                full;
  logic [PPM_W-1:0]    ppm_sel;
  logic [PPM_PROD_W-1:0] ppm_prod;
  logic [CORR_W-1:0]   ppm_q30;

  assign accept = item.valid && item.ready;
  assign cfg.ready = 1'b1;
  assign full = (fill_count == FILL_W'(FILTER_DEPTH));

  always_comb begin
    err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    rem_sh = {rem, divq[QUO_W-1]};
    rem_fits = (rem_sh >= {1'b0, dvs});
    rem_diff = rem_sh - {1'b0, dvs};
    qmag = (divq > QUO_W'(corr_q)) ? corr_q : divq[CORR_W-1:0];
    slew_lo = $signed(RAT_W'(ratio_now)) - $signed(RAT_W'(slew_q));
    slew_hi = $signed(RAT_W'(ratio_now)) + $signed(RAT_W'(slew_q));
    hi_clamped = (ratio_work > slew_hi) ? slew_hi : ratio_work;
    if (hi_clamped[RAT_W-1]) begin
      ratio_sat = '0;
    end else if (|hi_clamped[RAT_W-2:RATIO_W]) begin
      ratio_sat = '1;
    end else begin
      ratio_sat = hi_clamped[RATIO_W-1:0];
    end
    phase_sum = {1'b0, source_phase} + (PHASE_W+1)'(prod[PROD_W-1:PROD_SHIFT]);
    horizon_eff = (horizon == '0) ? HORIZON_W'(1) : horizon;
    err_ext = SUM_W'($signed(err[RING_W-1:0]));
    old_ext = SUM_W'($signed(ring_rd));
    // keep the error inside the 63-bit signed field
    if (err[ERR_W-1] != err[ERR_W-2]) begin
      err_sat = {err[ERR_W-1], {(PHASE_W-1){~err[ERR_W-1]}}};
    end else begin
      err_sat = err[PHASE_W-1:0];
    end
    // ppm to Q30 by reciprocal multiplication, slew limit while in ST_DEN
    ppm_sel = (state == ST_DEN) ? max_slew : max_corr;
    ppm_prod = PPM_PROD_W'(ppm_sel) * PPM_PROD_W'(PPM_FRAC_MUL);
    ppm_q30 = CORR_W'(ppm_sel) * CORR_W'(PPM_INT_MUL)
              + CORR_W'(ppm_prod[PPM_PROD_W-1:PPM_FRAC_SHIFT]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item.ready = 1'b0;
    ring_we = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        item.ready = 1'b1;
        if (item.valid) begin
          if (item.operation == OP_ARM || fault_latched) begin
            state_next = ST_EMIT;
          end else begin
            state_next = ST_ERR;
          end
        end
      end
      ST_ERR: state_next = ST_CHK;
      ST_CHK: begin
        if (err_mag > (ERR_W'(envelope) << FRAC_W)) begin
          state_next = ST_EMIT;
        end else begin
          ring_we = 1'b1;
          state_next = ST_SUM;
        end
      end
      ST_SUM: state_next = ST_DEN;
      ST_DEN: state_next = ST_DIV_LOAD;
      ST_DIV_LOAD: state_next = ST_DIVIDE;
      ST_DIVIDE: begin
        if (div_cnt == CNT_W'(1)) begin
          state_next = ST_REQ;
        end
      end
      ST_REQ: state_next = ST_SLEW_LO;
      ST_SLEW_LO: state_next = ST_SLEW_HI;
      ST_SLEW_HI: state_next = ST_MUL;
      ST_MUL: state_next = ST_ADV;
      ST_ADV: state_next = ST_EMIT;
      ST_EMIT: begin
        if (!result.valid || result.ready) begin
          out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // error ring, its read value never used before all of its entries are written since arm
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ring_position] <= err[RING_W-1:0];
    end
    ring_rd <= ring[ring_position];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_W'(256);
      envelope <= ENV_W'(4096);
      horizon <= HORIZON_W'(48000);
      max_corr <= PPM_W'(1000);
      max_slew <= PPM_W'(10);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PERIOD:   period <= cfg.data[PERIOD_W-1:0];
        REG_ENVELOPE: envelope <= cfg.data[ENV_W-1:0];
        REG_HORIZON:  horizon <= cfg.data[HORIZON_W-1:0];
        REG_MAX_CORR: max_corr <= cfg.data[PPM_W-1:0];
        REG_MAX_SLEW: max_slew <= cfg.data[PPM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_phase <= '0;
      error_sum <= '0;
      fill_count <= '0;
      ring_position <= '0;
      ratio_now <= RATIO_W'(ONE_Q30);
      fault_latched <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (out_load) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            target <= item.phase_value;
            report_err <= 1'b0;
            if (item.operation == OP_ARM) begin
              source_phase <= item.phase_value;
              error_sum <= '0;
              fill_count <= '0;
              ring_position <= '0;
              ratio_now <= RATIO_W'(ONE_Q30);
              fault_latched <= 1'b0;
            end
          end
        end
        ST_ERR: begin
          err <= $signed({1'b0, target}) - $signed({1'b0, source_phase});
        end
        ST_CHK: begin
          report_err <= 1'b1;
          if (err_mag > (ERR_W'(envelope) << FRAC_W)) begin
            fault_latched <= 1'b1;
          end else if (full) begin
            error_sum <= error_sum - old_ext;
          end
        end
        ST_SUM: begin
          error_sum <= error_sum + err_ext;
          corr_q <= ppm_q30;
          if (!full) begin
            fill_count <= fill_count + FILL_W'(1);
          end
          if (ring_position == POS_W'(FILTER_DEPTH - 1)) begin
            ring_position <= '0;
          end else begin
            ring_position <= ring_position + POS_W'(1);
          end
        end
        ST_DEN: begin
          den <= DEN_W'(fill_count) * DEN_W'(horizon_eff);
          sum_neg <= error_sum[SUM_W-1];
          smag <= error_sum[SUM_W-1] ? SMAG_W'(-error_sum) : SMAG_W'(error_sum);
          slew_q <= ppm_q30;
        end
        ST_DIV_LOAD: begin
          rem <= '0;
          div_cnt <= CNT_W'(QUO_W);
          divq <= {smag, {DELTA_SHIFT{1'b0}}};
          dvs <= den;
        end
        ST_DIVIDE: begin
          // restoring division, one quotient bit a cycle
          if (rem_fits) begin
            rem <= rem_diff[DEN_W-1:0];
            divq <= {divq[QUO_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh[DEN_W-1:0];
            divq <= {divq[QUO_W-2:0], 1'b0};
          end
          div_cnt <= div_cnt - CNT_W'(1);
        end
        ST_REQ: begin
          ratio_work <= sum_neg ? $signed(RAT_W'(ONE_Q30)) - $signed(RAT_W'(qmag))
                                : $signed(RAT_W'(ONE_Q30)) + $signed(RAT_W'(qmag));
        end
        ST_SLEW_LO: begin
          if (ratio_work < slew_lo) begin
            ratio_work <= slew_lo;
          end
        end
        ST_SLEW_HI: begin
          ratio_now <= ratio_sat;
        end
        ST_MUL: begin
          prod <= PROD_W'(ratio_now) * PROD_W'(period);
        end
        ST_ADV: begin
          source_phase <= phase_sum[PHASE_W] ? '1 : phase_sum[PHASE_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.resample_ratio <= ratio_now;
      result.phase_offset <= report_err ? err_sat : '0;
      result.fault <= fault_latched;
    end
  end

endmodule

>>> verif/phase_loop_checker.sv
module phase_loop_checker import aprc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  aprc_item_if   item,
  aprc_result_if result,
  aprc_cfg_if    cfg,
  output int     failures,
  output int     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [RATIO_W-1:0] ratio;
    logic [PHASE_W-1:0] error;
    logic               fault;
  } loop_result_t;

  localparam logic [63:0]        PHASE_TOP = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ERR_CEIL  = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ERR_FLOOR = -64'sh4000_0000_0000_0000;
  localparam logic signed [63:0] UNITY     = 64'sd1 <<< PPM_SHIFT;
  localparam logic signed [63:0] RATIO_TOP = 64'sh0000_0000_FFFF_FFFF;

  // register copies
  logic [63:0] period_frames_r, envelope_frames_r, horizon_frames_r;
  logic [63:0] corr_ppm_r, slew_ppm_r;

  // loop state
  logic [63:0]        src_phase;
  logic signed [63:0] err_hist [FILTER_DEPTH];
  logic signed [63:0] err_total;
  int unsigned        hist_count;
  int unsigned        hist_slot;
  logic signed [63:0] ratio_q30;
  bit                 faulted;

  loop_result_t loop_results_due[$];

  task automatic report(string what);
    $display("mismatch at %0t: %s", $time, what);
    failures++;
  endtask

  function automatic logic signed [63:0] clamp_s(logic signed [63:0] v, lo, hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [63:0] ppm_q30(logic [63:0] ppm);
    return $signed((ppm << PPM_SHIFT) / 64'(PPM_SCALE));
  endfunction

  function automatic void clear_filter();
    for (int i = 0; i < FILTER_DEPTH; i++) err_hist[i] = '0;
    err_total = '0;
    hist_count = 0;
    hist_slot = 0;
    ratio_q30 = UNITY;
    faulted = 1'b0;
  endfunction

  function automatic loop_result_t pack_result(logic signed [63:0] err);
    loop_result_t r;
    logic signed [63:0] e;
    e = clamp_s(err, ERR_FLOOR, ERR_CEIL);
    r.ratio = ratio_q30[RATIO_W-1:0];
    r.error = e[PHASE_W-1:0];
    r.fault = faulted;
    return r;
  endfunction

  // one period of the control loop, or an arm
  function automatic loop_result_t advance_loop(logic op, logic [PHASE_W-1:0] ph);
    logic [63:0]        target, mag, horizon, den, smag, adv;
    logic signed [63:0] err, delta, maxc, req, slew, slewed;
    bit                 neg;
    target = {1'b0, ph};
    if (op == OP_ARM) begin
      clear_filter();
      src_phase = target;
      return pack_result('0);
    end
    if (faulted) return pack_result('0);

    err = $signed(target - src_phase);
    mag = (err < 0) ? -err : err;
    if (mag > (envelope_frames_r << FRAC_W)) begin
      faulted = 1'b1;
      return pack_result(err);
    end

    if (hist_count < FILTER_DEPTH) begin
      hist_count++;
    end else begin
      err_total -= err_hist[hist_slot];
    end
    err_hist[hist_slot] = err;
    err_total += err;
    hist_slot = (hist_slot + 1) % FILTER_DEPTH;

    horizon = (horizon_frames_r == 0) ? 64'd1 : horizon_frames_r;
    den = 64'(hist_count) * horizon;
    neg = err_total < 0;
    smag = neg ? -err_total : err_total;
    delta = $signed((smag << DELTA_SHIFT) / den);
    if (neg) delta = -delta;

    maxc = ppm_q30(corr_ppm_r);
    req = UNITY + clamp_s(delta, -maxc, maxc);
    slew = ppm_q30(slew_ppm_r);
    slewed = clamp_s(req, ratio_q30 - slew, ratio_q30 + slew);
    ratio_q30 = clamp_s(slewed, '0, RATIO_TOP);

    adv = ($unsigned(ratio_q30) * period_frames_r) >> PROD_SHIFT;
    if (adv > PHASE_TOP - src_phase) src_phase = PHASE_TOP;
    else src_phase += adv;
    return pack_result(err);
  endfunction

  always @(posedge clk) begin : watch
    loop_result_t want;
    if (rst) begin
      period_frames_r = 64'd256;
      envelope_frames_r = 64'd4096;
      horizon_frames_r = 64'd48000;
      corr_ppm_r = 64'd1000;
      slew_ppm_r = 64'd10;
      src_phase = '0;
      clear_filter();
      loop_results_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_PERIOD:   period_frames_r = 64'(cfg.data[PERIOD_W-1:0]);
          REG_ENVELOPE: envelope_frames_r = 64'(cfg.data[ENV_W-1:0]);
          REG_HORIZON:  horizon_frames_r = 64'(cfg.data[HORIZON_W-1:0]);
          REG_MAX_CORR: corr_ppm_r = 64'(cfg.data[PPM_W-1:0]);
          REG_MAX_SLEW: slew_ppm_r = 64'(cfg.data[PPM_W-1:0]);
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (loop_results_due.size() == 0) begin
          report("result transaction with nothing outstanding");
        end else begin
          want = loop_results_due.pop_front();
          if (result.resample_ratio !== want.ratio)
            report($sformatf("resample_ratio %h, expected %h", result.resample_ratio,
                             want.ratio));
          if (result.phase_offset !== want.error)
            report($sformatf("phase_offset %h, expected %h", result.phase_offset,
                             want.error));
          if (result.fault !== want.fault)
            report($sformatf("fault %b, expected %b", result.fault, want.fault));
        end
      end
      if (item.valid && item.ready)
        loop_results_due.push_back(advance_loop(item.operation, item.phase_value));
    end
    outstanding <= loop_results_due.size();
  end

endmodule

>>> verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import aprc_pkg::*;

  localparam logic [PHASE_W-1:0] PHASE_ALL = '1;
  localparam logic [PHASE_W-1:0] ENV_SPAN = 63'(4096) << FRAC_W;

  logic clk;
  logic rst;

  aprc_item_if   item();
  aprc_result_if result();
  aprc_cfg_if    cfg();

  int failures;
  int outstanding;
  bit quiet;
  bit hold_req;

  logic [PERIOD_W-1:0] period_set;
  logic [ENV_W-1:0]    envelope_set;
  int                  items_sent;
  int                  arms_sent;
  int                  settings_run;

  audio_phase_rate_control_loop uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg    (cfg)
  );

  phase_loop_checker loop_check (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .result      (result),
    .cfg         (cfg),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #25ms;
    $display("TEST FAILED");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result.ready <= 1'b0;
        repeat (1500) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        result.ready <= quiet || ($urandom_range(99) >= 16);
      end
    end
  end

  function automatic logic [63:0] wide_random();
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(logic op, logic [PHASE_W-1:0] ph);
    item.valid <= 1'b1;
    item.operation <= op;
    item.phase_value <= ph;
    do @(posedge clk); while (!item.ready);
    items_sent++;
    if (op == OP_ARM) arms_sent++;
    if (!quiet && $urandom_range(99) < 16) begin
      item.valid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 250 : 8)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    item.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic apply_setting(logic [CFG_DATA_W-1:0] p, e, h, c, s);
    wait_drained();
    write_reg(REG_PERIOD, p);
    write_reg(REG_ENVELOPE, e);
    write_reg(REG_HORIZON, h);
    write_reg(REG_MAX_CORR, c);
    write_reg(REG_MAX_SLEW, s);
    cfg.valid <= 1'b0;
    period_set = p[PERIOD_W-1:0];
    envelope_set = e[ENV_W-1:0];
    settings_run++;
  endtask

  // mostly arm followed by a tracking run of updates, with some random noise
  task automatic run_phase(int count);
    logic [63:0]        nominal, step, bound;
    logic signed [63:0] drift, jitter;
    int                 sent;
    int                 run_len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 10) begin
        send_item(1'($urandom_range(1)), 63'(wide_random()));
        sent++;
      end else begin
        nominal = wide_random() >> $urandom_range(1, 40);
        send_item(OP_ARM, 63'(nominal));
        sent++;
        step = 64'(period_set) << FRAC_W;
        drift = $signed((step >> $urandom_range(6, 16)) + 64'($urandom_range(4096)));
        if ($urandom_range(1)) drift = -drift;
        run_len = $urandom_range(6, 50);
        while (run_len > 0 && sent < count) begin
          nominal = nominal + step + drift;
          bound = (64'(envelope_set) << FRAC_W) >> $urandom_range(2, 8);
          jitter = $signed(wide_random() % (2 * bound + 1)) - $signed(bound);
          send_item(OP_UPDATE, 63'(nominal + jitter));
          sent++;
          run_len--;
        end
      end
    end
  endtask

  initial begin
    logic [PHASE_W-1:0] base;
    rst <= 1'b1;
    item.valid <= 1'b0;
    item.operation <= OP_ARM;
    item.phase_value <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= REG_PERIOD;
    cfg.data <= '0;
    period_set = 14'd256;
    envelope_set = 24'd4096;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: boundaries of the envelope, output saturation, fault, phase ceiling
    send_item(OP_UPDATE, '0);
    send_item(OP_ARM, '0);
    send_item(OP_UPDATE, ENV_SPAN);
    send_item(OP_UPDATE, PHASE_ALL);
    send_item(OP_UPDATE, 63'd12345);
    send_item(OP_ARM, PHASE_ALL);
    send_item(OP_UPDATE, PHASE_ALL - ENV_SPAN);
    send_item(OP_UPDATE, PHASE_ALL);
    send_item(OP_UPDATE, '0);
    base = 63'(1) << 40;
    send_item(OP_ARM, base);
    send_item(OP_UPDATE, base + ENV_SPAN + 63'd1);
    send_item(OP_ARM, base);
    send_item(OP_UPDATE, base - ENV_SPAN - 63'd1);
    send_item(OP_ARM, base);
    repeat (8) begin
      base = base + (63'(256) << FRAC_W) + 63'd3000;
      send_item(OP_UPDATE, base);
    end

    apply_setting(24'd1, 24'd0, 24'd1, 24'd0, 24'd0);
    run_phase(60);
    apply_setting(24'd8192, 24'hFF_FFFF, 24'hFF_FFFF, 24'd100000, 24'd100000);
    hold_req = 1'b1;
    run_phase(140);
    // zero period and zero horizon
    apply_setting(24'd0, 24'd4096, 24'd0, 24'd1000, 24'd100);
    run_phase(140);
    quiet = 1'b1;
    apply_setting(24'd480, 24'd2000, 24'd48000, 24'd100000, 24'd100000);
    run_phase(140);
    quiet = 1'b0;
    repeat (4) begin
      apply_setting(24'($urandom_range(1, 8192)), 24'($urandom_range(16, 65536)),
                    24'($urandom_range(1, 200000)), 24'($urandom_range(100000)),
                    24'($urandom_range(100000)));
      run_phase(140);
    end

    wait_drained();
    repeat (400) @(posedge clk);
    $display("covered %0d items (%0d arms) over %0d register settings plus reset values,",
             items_sent, arms_sent, settings_run);
    $display("including a long result hold-off and a stretch without idling");
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
